[design/sep_pkg.sv]
// Shared constants, widths and constant functions of the sinusoidal position encoder.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package sep_pkg;

	// Field widths of the transactions and of the register.
	localparam int POS_W = 12;
	localparam int IDX_W = 10;
	localparam int DIM_W = 11;
	localparam int ENC_W = 16;

	// Largest embedding size used in the exponent.
	localparam int MAX_DIM = 1024;

	// Reset value and register index of model_dim.
	localparam logic [DIM_W-1:0] MODEL_DIM_RST = 11'd512;
	localparam logic REG_MODEL_DIM_IDX = 1'b0;

	// Fixed-point constants: log2(10000) in Q.24, 2*pi and pi/2 in Q.31, 1.0 in Q.30.
	localparam logic [27:0] LOG2_10000_Q24 = 28'd222930821;
	localparam logic [43:0] TWO_PI_Q31 = 44'd13493037705;
	localparam logic [33:0] HALF_PI_Q31 = 34'd3373259426;
	localparam logic [30:0] ONE_Q30 = 31'd1073741824;

	// Integer square root, one result bit per iteration.
	function automatic logic [63:0] sep_isqrt(input logic [63:0] v);
		logic [63:0] val;
		logic [63:0] res;
		logic [63:0] bt;
		val = v;
		res = '0;
		bt = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (val >= res + bt) begin
				val = val - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
			bt = bt >> 2;
		end
		return res;
	endfunction

	// Factor 2^(-2^-m) in Q.31, built by repeated square roots from 0.5.
	function automatic logic [31:0] sep_p_const(input int m);
		logic [63:0] p;
		p = 64'd1 << 30;
		for (int j = 1; j <= 24; j++) begin
			if (j <= m) begin
				p = sep_isqrt(p << 31);
			end
		end
		return p[31:0];
	endfunction

endpackage

`default_nettype wire

[design/sep_in_if.sv]
// Input channel of the encoder: one (position, dim_index) pair per transaction.
// Depends on sep_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface sep_in_if import sep_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [POS_W-1:0] position;
	logic [IDX_W-1:0] dim_index;

	modport source (output valid, output position, output dim_index, input ready);
	modport sink (input valid, input position, input dim_index, output ready);
endinterface

`default_nettype wire

[design/sep_out_if.sv]
// Output channel of the encoder: one Q1.14 encoding value per transaction.
// Depends on sep_pkg for the field width.
`timescale 1ns / 1ps
`default_nettype none

interface sep_out_if import sep_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [ENC_W-1:0] enc_value;

	modport source (output valid, output enc_value, input ready);
	modport sink (input valid, input enc_value, output ready);
endinterface

`default_nettype wire

[design/sinusoidal_position_encoder_unit.sv]
// Top level of the sinusoidal position encoder: APB register, full datapath pipeline.
// Depends on sep_pkg, sep_in_if and sep_out_if.
`timescale 1ns / 1ps
`default_nettype none

// The unit takes one (position, dim_index) transaction per clock and returns the
// positional-encoding value sin or cos of position / 10000^(2*floor(dim_index/2)/model_dim)
// in Q1.14. Throughput is one transaction per cycle while req.ready is high, from a single
// pipeline of 62 register stages: a radix-2 divider for the exponent (8 bits per stage), 24
// multiply stages for the fractional power of two, a product and shift, a modulo-2*pi
// reduction (two subtract steps per stage), the quadrant split, and three stages per term of
// the sine and cosine series. The whole pipeline advances together; a one-entry skid register
// behind the output register lets one more transaction in while a result waits, after which
// req.ready drops until rsp takes a result. model_dim is written through the APB port at byte
// address 0; the user must write it only while the unit is idle, which the block does not
// enforce. Values below 2 act as 2 and values above 1024 act as 1024.
module sinusoidal_position_encoder_unit import sep_pkg::*; (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          psel,
	input  wire          penable,
	input  wire          pwrite,
	input  wire  [2:0]   paddr,
	input  wire  [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	sep_in_if.sink       req,
	sep_out_if.source    rsp
);

	localparam int DIV_W   = 40;
	localparam int DIV_STG = 5;
	localparam int DIV_BPS = DIV_W / DIV_STG;
	localparam int EXP_STG = 24;
	localparam int MOD_STG = 5;
	localparam int SER_IT  = 7;

	localparam logic [33:0] H1 = HALF_PI_Q31;
	localparam logic [33:0] H2 = 34'(HALF_PI_Q31 * 2);
	localparam logic [33:0] H3 = 34'(HALF_PI_Q31 * 3);
	localparam logic [33:0] H4 = 34'(HALF_PI_Q31 * 4);

	// Values that ride along the series section.
	typedef struct packed {
		logic [30:0] x;
		logic [31:0] x2;
		logic [1:0]  quad;
		logic        odd;
	} car_t;

	// ---------------------------------------------------------------
	// Configuration register.
	logic [DIM_W-1:0] model_dim_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;
	assign prdata = (paddr[2] == REG_MODEL_DIM_IDX) ? 32'(model_dim_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_dim_q <= MODEL_DIM_RST;
		end else if (cfg_wr && paddr[2] == REG_MODEL_DIM_IDX) begin
			model_dim_q <= pwdata[DIM_W-1:0];
		end
	end

	// Clamp the embedding size to its legal range.
	logic [DIM_W-1:0] dim_clamp;
	always_comb begin
		if (model_dim_q < DIM_W'(2)) begin
			dim_clamp = DIM_W'(2);
		end else if (model_dim_q > DIM_W'(MAX_DIM)) begin
			dim_clamp = DIM_W'(MAX_DIM);
		end else begin
			dim_clamp = model_dim_q;
		end
	end

	// Whole pipeline advances while the skid register is empty.
	logic adv;
	logic skvld_q;
	assign adv = !skvld_q;
	assign req.ready = adv;

	// ---------------------------------------------------------------
	// Divider section: T = floor(k2 * log2(10000) / d), eight quotient bits per stage.
	logic             dvld_s [0:DIV_STG];
	logic [DIV_W-1:0] dnum_s [0:DIV_STG];
	logic [IDX_W-1:0] drem_s [0:DIV_STG];
	logic [DIM_W-1:0] dden_s [0:DIV_STG];
	logic [POS_W-1:0] dpos_s [0:DIV_STG];
	logic             dodd_s [0:DIV_STG];

	logic [IDX_W-1:0] k2;
	assign k2 = {req.dim_index[IDX_W-1:1], 1'b0};

	// First stage: form the dividend and capture the divisor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvld_s[0] <= 1'b0;
		end else if (adv) begin
			dvld_s[0] <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dnum_s[0] <= DIV_W'(k2) * DIV_W'(LOG2_10000_Q24);
			drem_s[0] <= '0;
			dden_s[0] <= dim_clamp;
			dpos_s[0] <= req.position;
			dodd_s[0] <= req.dim_index[0];
		end
	end

	for (genvar g = 0; g < DIV_STG; g++) begin : g_div
		logic [DIV_W-1:0] num_c;
		logic [IDX_W-1:0] rem_c;
		logic [DIM_W-1:0] r11;

		// Restoring division steps; the quotient shifts into the dividend word.
		always_comb begin
			num_c = dnum_s[g];
			rem_c = drem_s[g];
			r11 = '0;
			for (int j = 0; j < DIV_BPS; j++) begin
				r11 = {rem_c, num_c[DIV_W-1]};
				num_c = num_c << 1;
				if (r11 >= dden_s[g]) begin
					r11 = r11 - dden_s[g];
					num_c[0] = 1'b1;
				end
				rem_c = r11[IDX_W-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvld_s[g+1] <= 1'b0;
			end else if (adv) begin
				dvld_s[g+1] <= dvld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dnum_s[g+1] <= num_c;
				drem_s[g+1] <= rem_c;
				dden_s[g+1] <= dden_s[g];
				dpos_s[g+1] <= dpos_s[g];
				dodd_s[g+1] <= dodd_s[g];
			end
		end
	end

	// ---------------------------------------------------------------
	// Fractional power section: 2^-f in Q.31, one table factor per stage.
	logic             evld_s [0:EXP_STG];
	logic [31:0]      eacc_s [0:EXP_STG];
	logic [23:0]      ef_s   [0:EXP_STG];
	logic [5:0]       en6_s  [0:EXP_STG];
	logic             ebig_s [0:EXP_STG];
	logic [POS_W-1:0] epos_s [0:EXP_STG];
	logic             eodd_s [0:EXP_STG];

	assign evld_s[0] = dvld_s[DIV_STG];
	assign eacc_s[0] = 32'h8000_0000;
	assign ef_s[0]   = dnum_s[DIV_STG][23:0];
	assign en6_s[0]  = dnum_s[DIV_STG][29:24];
	assign ebig_s[0] = |dnum_s[DIV_STG][DIV_W-1:30];
	assign epos_s[0] = dpos_s[DIV_STG];
	assign eodd_s[0] = dodd_s[DIV_STG];

	for (genvar m = 1; m <= EXP_STG; m++) begin : g_exp
		localparam logic [31:0] PM = sep_p_const(m);
		logic [63:0] prod_c;

		assign prod_c = 64'(eacc_s[m-1]) * 64'(PM);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				evld_s[m] <= 1'b0;
			end else if (adv) begin
				evld_s[m] <= evld_s[m-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				eacc_s[m] <= ef_s[m-1][EXP_STG-m] ? prod_c[62:31] : eacc_s[m-1];
				ef_s[m]   <= ef_s[m-1];
				en6_s[m]  <= en6_s[m-1];
				ebig_s[m] <= ebig_s[m-1];
				epos_s[m] <= epos_s[m-1];
				eodd_s[m] <= eodd_s[m-1];
			end
		end
	end

	// ---------------------------------------------------------------
	// Angle product: position times the power of two.
	logic        pvld_s;
	logic [43:0] prod_s;
	logic [5:0]  pn6_s;
	logic        pbig_s;
	logic        podd_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvld_s <= 1'b0;
		end else if (adv) begin
			pvld_s <= evld_s[EXP_STG];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s <= 44'(epos_s[EXP_STG]) * 44'(eacc_s[EXP_STG]);
			pn6_s  <= en6_s[EXP_STG];
			pbig_s <= ebig_s[EXP_STG];
			podd_s <= eodd_s[EXP_STG];
		end
	end

	// ---------------------------------------------------------------
	// Modulo 2*pi: the first register holds the shifted angle, then two steps per stage.
	logic        mvld_s [0:MOD_STG];
	logic [43:0] mang_s [0:MOD_STG];
	logic        modd_s [0:MOD_STG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mvld_s[0] <= 1'b0;
		end else if (adv) begin
			mvld_s[0] <= pvld_s;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mang_s[0] <= pbig_s ? 44'd0 : (prod_s >> pn6_s);
			modd_s[0] <= podd_s;
		end
	end

	for (genvar g = 0; g < MOD_STG; g++) begin : g_mod
		localparam logic [43:0] MK_HI = TWO_PI_Q31 << (2 * (MOD_STG - 1 - g) + 1);
		localparam logic [43:0] MK_LO = TWO_PI_Q31 << (2 * (MOD_STG - 1 - g));
		logic [43:0] a_hi;
		logic [43:0] a_lo;

		always_comb begin
			a_hi = (mang_s[g] >= MK_HI) ? mang_s[g] - MK_HI : mang_s[g];
			a_lo = (a_hi >= MK_LO) ? a_hi - MK_LO : a_hi;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				mvld_s[g+1] <= 1'b0;
			end else if (adv) begin
				mvld_s[g+1] <= mvld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				mang_s[g+1] <= a_lo;
				modd_s[g+1] <= modd_s[g];
			end
		end
	end

	// ---------------------------------------------------------------
	// Quadrant split against the four multiples of pi/2.
	logic [33:0] ang_r;
	logic [33:0] rem_q;
	logic [1:0]  quad_c;
	logic        qvld_s;
	logic [30:0] qx_s;
	logic [1:0]  qquad_s;
	logic        qodd_s;

	assign ang_r = mang_s[MOD_STG][33:0];

	always_comb begin
		if (ang_r >= H4) begin
			quad_c = 2'd0;
			rem_q = ang_r - H4;
		end else if (ang_r >= H3) begin
			quad_c = 2'd3;
			rem_q = ang_r - H3;
		end else if (ang_r >= H2) begin
			quad_c = 2'd2;
			rem_q = ang_r - H2;
		end else if (ang_r >= H1) begin
			quad_c = 2'd1;
			rem_q = ang_r - H1;
		end else begin
			quad_c = 2'd0;
			rem_q = ang_r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qvld_s <= 1'b0;
		end else if (adv) begin
			qvld_s <= mvld_s[MOD_STG];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			qx_s    <= rem_q[31:1];
			qquad_s <= quad_c;
			qodd_s  <= modd_s[MOD_STG];
		end
	end

	// ---------------------------------------------------------------
	// Series section: the first register holds x squared and the starting terms.
	logic        hv_s   [0:SER_IT];
	logic [30:0] hts_s  [0:SER_IT];
	logic [30:0] htc_s  [0:SER_IT];
	car_t        hcar_s [0:SER_IT];

	logic [61:0] xsq_c;
	assign xsq_c = 62'(qx_s) * 62'(qx_s);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hv_s[0] <= 1'b0;
		end else if (adv) begin
			hv_s[0] <= qvld_s;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hts_s[0]       <= ONE_Q30;
			htc_s[0]       <= ONE_Q30;
			hcar_s[0].x    <= qx_s;
			hcar_s[0].x2   <= xsq_c[61:30];
			hcar_s[0].quad <= qquad_s;
			hcar_s[0].odd  <= qodd_s;
		end
	end

	for (genvar i = 0; i < SER_IT; i++) begin : g_ser
		localparam bit SIN_ON = (i < SER_IT - 1);
		localparam int KS = 13 - 2 * i;
		localparam int KC = 14 - 2 * i;
		localparam logic [7:0] DS = SIN_ON ? 8'(KS * (KS - 1)) : 8'd2;
		localparam logic [7:0] DC = 8'(KC * (KC - 1));
		localparam logic [31:0] MS = 32'((64'd1 << 32) / DS);
		localparam logic [31:0] MC = 32'((64'd1 << 32) / DC);

		logic        av_s;
		logic [31:0] ays_s;
		logic [31:0] ayc_s;
		logic [30:0] ats_s;
		car_t        acar_s;
		logic        bv_s;
		logic [31:0] bys_s;
		logic [31:0] byc_s;
		logic [31:0] bqs_s;
		logic [31:0] bqc_s;
		logic [30:0] bts_s;
		car_t        bcar_s;

		logic [63:0] ps_c;
		logic [63:0] pc_c;
		logic [63:0] rs_c;
		logic [63:0] rc_c;
		logic [39:0] es_c;
		logic [39:0] ec_c;
		logic [31:0] ds_c;
		logic [31:0] dc_c;
		logic [30:0] ts_c;
		logic [30:0] tc_c;

		// Stage A: x^2 times the running term.
		assign ps_c = 64'(hcar_s[i].x2) * 64'(hts_s[i]);
		assign pc_c = 64'(hcar_s[i].x2) * 64'(htc_s[i]);

		// Stage B: quotient estimate by the reciprocal of k*(k-1).
		assign rs_c = 64'(ays_s) * 64'(MS);
		assign rc_c = 64'(ayc_s) * 64'(MC);

		// Stage C: correct the estimate by one and form the next term.
		always_comb begin
			es_c = 40'(bys_s) - 40'(bqs_s) * 40'(DS);
			ec_c = 40'(byc_s) - 40'(bqc_s) * 40'(DC);
			ds_c = (es_c >= 40'(DS)) ? bqs_s + 32'd1 : bqs_s;
			dc_c = (ec_c >= 40'(DC)) ? bqc_s + 32'd1 : bqc_s;
			ts_c = (ds_c > 32'(ONE_Q30)) ? 31'd0 : ONE_Q30 - ds_c[30:0];
			tc_c = (dc_c > 32'(ONE_Q30)) ? 31'd0 : ONE_Q30 - dc_c[30:0];
			if (!SIN_ON) begin
				ts_c = bts_s;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				av_s      <= 1'b0;
				bv_s      <= 1'b0;
				hv_s[i+1] <= 1'b0;
			end else if (adv) begin
				av_s      <= hv_s[i];
				bv_s      <= av_s;
				hv_s[i+1] <= bv_s;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				ays_s       <= ps_c[61:30];
				ayc_s       <= pc_c[61:30];
				ats_s       <= hts_s[i];
				acar_s      <= hcar_s[i];
				bys_s       <= ays_s;
				byc_s       <= ayc_s;
				bqs_s       <= rs_c[63:32];
				bqc_s       <= rc_c[63:32];
				bts_s       <= ats_s;
				bcar_s      <= acar_s;
				hts_s[i+1]  <= ts_c;
				htc_s[i+1]  <= tc_c;
				hcar_s[i+1] <= bcar_s;
			end
		end
	end

	// ---------------------------------------------------------------
	// Sine magnitude: x times the sine series.
	logic        fv_s;
	logic [30:0] fsin_s;
	logic [30:0] fcos_s;
	logic [1:0]  fquad_s;
	logic        fodd_s;
	logic [61:0] sin_c;

	assign sin_c = 62'(hcar_s[SER_IT].x) * 62'(hts_s[SER_IT]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fv_s <= 1'b0;
		end else if (adv) begin
			fv_s <= hv_s[SER_IT];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fsin_s  <= sin_c[60:30];
			fcos_s  <= htc_s[SER_IT];
			fquad_s <= hcar_s[SER_IT].quad;
			fodd_s  <= hcar_s[SER_IT].odd;
		end
	end

	// Pick sine or cosine and the sign by quadrant, then round to Q1.14.
	logic                    sel_cos;
	logic                    neg;
	logic [30:0]             mag_v;
	logic [31:0]             rnd_c;
	logic [ENC_W-1:0]        mag16;
	logic signed [ENC_W-1:0] enc_c;

	always_comb begin
		if (!fodd_s) begin
			sel_cos = fquad_s[0];
			neg = fquad_s[1];
		end else begin
			sel_cos = !fquad_s[0];
			neg = fquad_s[0] ^ fquad_s[1];
		end
		mag_v = sel_cos ? fcos_s : fsin_s;
		rnd_c = 32'(mag_v) + 32'd32768;
		mag16 = rnd_c[31:16];
		enc_c = neg ? -$signed(mag16) : $signed(mag16);
	end

	// ---------------------------------------------------------------
	// Output register and skid register.
	logic                    ovld_q;
	logic signed [ENC_W-1:0] odat_q;
	logic signed [ENC_W-1:0] skdat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q  <= 1'b0;
			skvld_q <= 1'b0;
		end else if (adv) begin
			if (!ovld_q || rsp.ready) begin
				ovld_q <= fv_s;
			end else if (fv_s) begin
				skvld_q <= 1'b1;
			end
		end else if (rsp.ready) begin
			ovld_q  <= 1'b1;
			skvld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (!ovld_q || rsp.ready) begin
				odat_q <= enc_c;
			end else begin
				skdat_q <= enc_c;
			end
		end else if (rsp.ready) begin
			odat_q <= skdat_q;
		end
	end

	assign rsp.valid     = ovld_q;
	assign rsp.enc_value = odat_q;

endmodule

`default_nettype wire
